/* design/gtb_pkg.sv */
// Shared types, codes and constants for the grayscale-to-braille text unit.
`default_nettype none
package gtb_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD    = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_index_t;

	localparam logic [7:0]  THRESHOLD_RST = 8'd127;
	localparam logic [10:0] WIDTH_RST     = 11'd1024;
	localparam logic [15:0] HEIGHT_RST    = 16'd1024;

	// UTF-8 framing of a braille code point U+2800..U+28FF
	localparam logic [7:0] UTF8_LEAD  = 8'hE2;
	localparam logic [7:0] UTF8_HI    = 8'hA0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [7:0] LOW6_MASK  = 8'h3F;
	localparam logic [7:0] NEWLINE    = 8'h0A;

	// position of a byte inside the run caused by one pixel
	typedef enum logic [1:0] {
		BYTE_LEAD = 2'd0,
		BYTE_HI   = 2'd1,
		BYTE_LO   = 2'd2,
		BYTE_NL   = 2'd3
	} byte_sel_t;

	// braille dot bit for a band row and a cell column
	function automatic logic [7:0] dot_mask(input logic [1:0] band_row, input logic col);
		logic [2:0] pos;
		unique case (band_row)
			2'd0: pos = col ? 3'd3 : 3'd0;
			2'd1: pos = col ? 3'd4 : 3'd1;
			2'd2: pos = col ? 3'd5 : 3'd2;
			2'd3: pos = col ? 3'd7 : 3'd6;
			default: pos = 3'd0;
		endcase
		return 8'd1 << pos;
	endfunction

endpackage
`default_nettype wire

/* design/gtb_pixel_if.sv */
// Pixel input channel: valid/ready with one gray value per beat.
`default_nettype none
interface gtb_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface
`default_nettype wire

/* design/gtb_byte_if.sv */
// Text output channel: valid/ready with one byte and its markers per beat.
`default_nettype none
interface gtb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       image_end;

	modport source(output valid, output out_byte, output run_last, output image_end,
		input ready);
	modport sink(input valid, input out_byte, input run_last, input image_end,
		output ready);
endinterface
`default_nettype wire

/* design/gtb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/gray_to_braille_utf8_unit.sv */
// Top level: grayscale pixels in, UTF-8 braille dot-art text out.
//
//  channel   dir  beat payload                       accepted when
//  pix_in    in   pixel[7:0]                         pix_in.valid & pix_in.ready
//  byte_out  out  out_byte[7:0], run_last, image_end byte_out.valid & byte_out.ready
//  cfg       in   cfg_index[1:0], cfg_wdata[15:0]    cfg_we
//
// Flow: a pixel is registered into s1 on acceptance while its cell pattern is
// read from the cell store; s1 merges its dot and writes the store back. Pixels
// that emit nothing flow at one per cycle. An emitting pixel moves to the s2
// output register and sends 3 bytes (4 with the band newline), one per cycle while
// byte_out.ready is high, so emitting band rows are paced by the byte-wide output.
// Reset (arst_n low) clears counters, config and valid flags; the cell store
// needs no clearing since each band's first row rewrites its entries.
// A stalled output holds s2; an emitting pixel in s1 then waits and pix_in.ready drops.
`default_nettype none
module gray_to_braille_utf8_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gtb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gtb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gtb_pixel_if.sink                          pix_in,
	gtb_byte_if.source                         byte_out
);

	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_WIDTH);
	// wide enough for the 11-bit width register and for MAX_WIDTH itself
	localparam int WW    = (CW + 1 > 12) ? CW + 1 : 12;

	// configuration
	logic [7:0]  threshold_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= gtb_pkg::THRESHOLD_RST;
			width_q     <= gtb_pkg::WIDTH_RST;
			height_q    <= gtb_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (gtb_pkg::cfg_index_t'(cfg_index))
				gtb_pkg::CFG_THRESHOLD:    threshold_q <= cfg_wdata[7:0];
				gtb_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg_wdata[10:0];
				gtb_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// raster position of the next pixel
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	logic [WW-1:0] eff_width;
	logic [15:0]   eff_height;
	logic          row_end;
	logic          last_row;
	logic          emit_row;
	logic [1:0]    band_row;
	logic [CW-1:0] col_half;
	logic [AW-1:0] cell_in;
	logic [7:0]    dot_in;
	logic          accept;

	always_comb begin
		if (width_q == 11'd0) begin
			eff_width = WW'(1);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			eff_width = WW'(MAX_WIDTH);
		end else begin
			eff_width = WW'(width_q);
		end
		eff_height = (height_q == 16'd0) ? 16'd1 : height_q;
		row_end    = (WW'(col_q) + WW'(1)) >= eff_width;
		last_row   = ({1'b0, row_q} + 17'd1) >= {1'b0, eff_height};
		band_row   = row_q[1:0];
		emit_row   = (band_row == 2'd3) || last_row;
		col_half   = col_q >> 1;
		cell_in    = col_half[AW-1:0];
		dot_in     = (pix_in.pixel > threshold_q) ? gtb_pkg::dot_mask(band_row, col_q[0])
			: 8'd0;
	end

	// stage 1: pixel registered, store entry being read
	logic          valid_s1;
	logic [AW-1:0] cell_s1;
	logic [7:0]    dot_s1;
	logic          first_row_s1;
	logic          emit_cell_s1;
	logic          emit_nl_s1;
	logic          end_s1;
	logic          byp_s1;
	logic [7:0]    byp_pat_s1;
	logic [7:0]    rd_pat;
	logic [7:0]    pat_s1;
	logic          adv_s1;

	// stage 2: output register walking through the bytes of one run
	logic                  valid_s2;
	logic [7:0]            pat_s2;
	logic                  nl_s2;
	logic                  end_s2;
	gtb_pkg::byte_sel_t    sel_s2;
	logic                  last_beat;
	logic                  done_s2;

	assign last_beat = (sel_s2 == gtb_pkg::BYTE_NL)
		|| ((sel_s2 == gtb_pkg::BYTE_LO) && !nl_s2);
	assign done_s2   = valid_s2 && byte_out.ready && last_beat;
	assign adv_s1    = valid_s1 && (!emit_cell_s1 || !valid_s2 || done_s2);
	assign pix_in.ready = !valid_s1 || adv_s1;
	assign accept    = pix_in.valid && pix_in.ready;

	// the store write at this edge is invisible to a read at the same edge
	assign pat_s1 = first_row_s1 ? dot_s1 : ((byp_s1 ? byp_pat_s1 : rd_pat) | dot_s1);

	gtb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_cell_store (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(cell_s1),
		.wdata(pat_s1),
		.re   (accept),
		.raddr(cell_in),
		.rdata(rd_pat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1      <= cell_in;
			dot_s1       <= dot_in;
			first_row_s1 <= (band_row == 2'd0);
			emit_cell_s1 <= emit_row && (col_q[0] || row_end);
			emit_nl_s1   <= emit_row && row_end;
			end_s1       <= last_row;
			byp_s1       <= adv_s1 && (cell_s1 == cell_in);
			byp_pat_s1   <= pat_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sel_s2   <= gtb_pkg::BYTE_LEAD;
		end else begin
			if (adv_s1 && emit_cell_s1) begin
				valid_s2 <= 1'b1;
				sel_s2   <= gtb_pkg::BYTE_LEAD;
			end else if (done_s2) begin
				valid_s2 <= 1'b0;
			end else if (valid_s2 && byte_out.ready) begin
				sel_s2 <= gtb_pkg::byte_sel_t'(sel_s2 + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_cell_s1) begin
			pat_s2 <= pat_s1;
			nl_s2  <= emit_nl_s1;
			end_s2 <= end_s1;
		end
	end

	always_comb begin
		unique case (sel_s2)
			gtb_pkg::BYTE_LEAD: byte_out.out_byte = gtb_pkg::UTF8_LEAD;
			gtb_pkg::BYTE_HI:   byte_out.out_byte = gtb_pkg::UTF8_HI | {6'd0, pat_s2[7:6]};
			gtb_pkg::BYTE_LO:   byte_out.out_byte = gtb_pkg::UTF8_CONT
				| (pat_s2 & gtb_pkg::LOW6_MASK);
			gtb_pkg::BYTE_NL:   byte_out.out_byte = gtb_pkg::NEWLINE;
			default:            byte_out.out_byte = gtb_pkg::NEWLINE;
		endcase
	end

	assign byte_out.valid     = valid_s2;
	assign byte_out.run_last  = last_beat;
	assign byte_out.image_end = (sel_s2 == gtb_pkg::BYTE_NL) && end_s2;

	// an emitting pixel only leaves s1 into a free or draining output register
	a_s2_free: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && emit_cell_s1) |-> (!valid_s2 || done_s2))
		else $error("s1 overwrote a busy output register");

	// the newline beat exists only for runs that end a band row
	a_nl_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !nl_s2) |-> (sel_s2 != gtb_pkg::BYTE_NL))
		else $error("newline beat without band end");

	// the last pixel of the image returns the raster position to the origin
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end && last_row) |=> (col_q == '0 && row_q == 16'd0))
		else $error("raster position did not wrap at image end");

	// input stalls only behind a pixel waiting in s1
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (valid_s1 && emit_cell_s1 && valid_s2))
		else $error("input stalled without a blocked pixel");

endmodule
`default_nettype wire
